>>> hw/rtl/asa_pkg.sv
// Shared types, constants and helper functions of the angular slot assigner.
// Used by every other file of the block but asa_if; depends on nothing.
`default_nettype none

package asa_pkg;

  // Default sizes; the first two are handed to the top-level parameters.
  localparam int MAX_BLADES_DEF   = 8;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int SLOT_COUNT       = 5;
  localparam int ATAN_LEN         = 24;
  localparam int QUEUE_DEPTH      = 4;

  // Width of the CORDIC vector registers: a 17-bit vector scaled by 2^16 plus gain.
  localparam int VEC_W = 36;

  // Configuration register reset values.
  localparam logic [15:0] SLOT_SPACING_RST   = 16'd13107;
  localparam logic [15:0] SLOT_TOLERANCE_RST = 16'd6554;
  localparam logic [10:0] WRAP_TOLERANCE_RST = 11'd10;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_SLOT_SPACING   = 2'd0,
    CFG_SLOT_TOLERANCE = 2'd1,
    CFG_WRAP_TOLERANCE = 2'd2
  } cfg_index_t;

  // Frame status codes.
  typedef enum logic [1:0] {
    ST_SOLVED  = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_DROPPED = 2'd2
  } status_t;

  // One classified item passed from the front to the back.
  typedef struct packed {
    logic               present;
    logic               frame_end;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [3:0]         label;
    logic [15:0]        angle;
  } blade_entry_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CALC,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SRCH,
    B_KEY,
    B_SORT,
    B_EMIT
  } back_state_t;

  // atan(2^-i) in 2^-32 turn units.
  function automatic logic [31:0] atan_step(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051D;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2E;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2F9;
      5'd15:   r = 32'h0000517C;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A2F;
      5'd19:   r = 32'h00000517;
      5'd20:   r = 32'h0000028B;
      5'd21:   r = 32'h00000145;
      5'd22:   r = 32'h000000A2;
      5'd23:   r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/asa_if.sv
// Valid/ready channel interfaces of the angular slot assigner.
// Blade input, slot result output and configuration write channels.
`default_nettype none

interface asa_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] center_x;
  logic signed [15:0] center_y;
  logic signed [15:0] blade_x;
  logic signed [15:0] blade_y;
  logic [3:0]         blade_label;
  logic               blade_present;
  logic               frame_end;

  modport source (output valid, center_x, center_y, blade_x, blade_y, blade_label,
                  blade_present, frame_end, input ready);
  modport sink (input valid, center_x, center_y, blade_x, blade_y, blade_label,
                blade_present, frame_end, output ready);
endinterface

interface asa_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         slot_index;
  logic               lit;
  logic               is_target;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic [3:0]         matched_label;
  logic signed [16:0] relative_angle;
  logic [3:0]         target_label;
  logic [15:0]        tgt_angle;
  logic [3:0]         blade_count;
  logic [1:0]         status;
  logic               last;

  modport source (output valid, slot_index, lit, is_target, point_x, point_y, matched_label,
                  relative_angle, target_label, tgt_angle, blade_count, status, last,
                  input ready);
  modport sink (input valid, slot_index, lit, is_target, point_x, point_y, matched_label,
                relative_angle, target_label, tgt_angle, blade_count, status, last,
                output ready);
endinterface

interface asa_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/asa_front.sv
// Front part: accepts blade items and finds each blade angle with an iterative CORDIC.
// Depends on asa_pkg and asa_if; feeds the queue with classified entries.
`default_nettype none

module asa_front #(
  parameter int CORDIC_STEPS = asa_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  asa_in_if.sink              blade_in,
  output asa_pkg::blade_entry_t push_data,
  output logic                push_valid,
  input  wire logic           push_ready
);

  localparam int SW = $clog2(CORDIC_STEPS);
  localparam int VW = asa_pkg::VEC_W;

  asa_pkg::front_state_t state, state_next;

  logic                 present;
  logic                 frame_end;
  logic signed [15:0]   bx;
  logic signed [15:0]   by;
  logic [3:0]           label;
  logic signed [VW-1:0] x;
  logic signed [VW-1:0] y;
  logic [31:0]          acc;
  logic [SW-1:0]        step;

  logic signed [16:0]   vx;
  logic signed [16:0]   vy;
  logic signed [VW-1:0] x0;
  logic signed [VW-1:0] y0;
  logic signed [VW-1:0] xs;
  logic signed [VW-1:0] ys;
  logic                 nonzero;
  logic                 steps_done;
  logic [31:0]          acc_round;
  logic [31:0]          tab;

  // Hub-relative vector, scaled by 2^16.
  assign vx = 17'(blade_in.blade_x) - 17'(blade_in.center_x);
  assign vy = 17'(blade_in.blade_y) - 17'(blade_in.center_y);
  assign x0 = {{(VW - 33){vx[16]}}, vx, 16'd0};
  assign y0 = {{(VW - 33){vy[16]}}, vy, 16'd0};
  assign nonzero = (vx != 17'sd0) || (vy != 17'sd0);

  // One vectoring step per cycle.
  assign xs = x >>> step;
  assign ys = y >>> step;
  assign tab = asa_pkg::atan_step(5'(step));
  assign steps_done = (step == SW'(CORDIC_STEPS - 1));

  assign acc_round = acc + 32'h0000_8000;

  // Next state and handshakes.
  always_comb begin
    state_next = state;
    unique case (state)
      asa_pkg::F_IDLE: begin
        if (blade_in.valid) begin
          state_next = (blade_in.blade_present && nonzero) ? asa_pkg::F_CALC
                                                           : asa_pkg::F_PUSH;
        end
      end
      asa_pkg::F_CALC: begin
        if (steps_done) state_next = asa_pkg::F_PUSH;
      end
      asa_pkg::F_PUSH: begin
        if (push_ready) state_next = asa_pkg::F_IDLE;
      end
      default: state_next = asa_pkg::F_IDLE;
    endcase
  end

  assign blade_in.ready = (state == asa_pkg::F_IDLE);
  assign push_valid     = (state == asa_pkg::F_PUSH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= asa_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Item capture and CORDIC datapath.
  always_ff @(posedge clk) begin
    if (state == asa_pkg::F_IDLE && blade_in.valid) begin
      present   <= blade_in.blade_present;
      frame_end <= blade_in.frame_end;
      bx        <= blade_in.blade_x;
      by        <= blade_in.blade_y;
      label     <= blade_in.blade_label;
      step      <= '0;
      if (!nonzero) begin
        acc <= 32'd0;
        x   <= x0;
        y   <= y0;
      end else if (vx[16]) begin
        acc <= 32'h8000_0000;
        x   <= -x0;
        y   <= -y0;
      end else begin
        acc <= 32'd0;
        x   <= x0;
        y   <= y0;
      end
    end else if (state == asa_pkg::F_CALC) begin
      step <= step + SW'(1);
      if (!y[VW-1]) begin
        x   <= x + ys;
        y   <= y - xs;
        acc <= acc + tab;
      end else begin
        x   <= x - ys;
        y   <= y + xs;
        acc <= acc - tab;
      end
    end
  end

  // A zero vector keeps the accumulator at zero, which rounds to angle zero.
  always_comb begin
    push_data           = '0;
    push_data.present   = present;
    push_data.frame_end = frame_end;
    push_data.x         = bx;
    push_data.y         = by;
    push_data.label     = label;
    push_data.angle     = acc_round[31:16];
  end

endmodule

`default_nettype wire

>>> hw/rtl/asa_queue.sv
// Short queue between the front and the back of the angular slot assigner.
// Depends on asa_pkg for the entry type and the depth.
`default_nettype none

module asa_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire asa_pkg::blade_entry_t push_data,
  input  wire logic                  push_valid,
  output logic                       push_ready,
  output asa_pkg::blade_entry_t      pop_data,
  output logic                       pop_valid,
  input  wire logic                  pop_ready
);

  localparam int DEPTH = asa_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);

  asa_pkg::blade_entry_t mem [DEPTH];

  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   fill;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (fill != (PW + 1)'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PW'(1);
      if (do_pop)  rd_ptr <= rd_ptr + PW'(1);
      if (do_push && !do_pop) begin
        fill <= fill + (PW + 1)'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - (PW + 1)'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

>>> hw/rtl/asa_back.sv
// Back part: stores a frame's blades, picks the target, sorts and fills the slots.
// Depends on asa_pkg and asa_if; holds the configuration registers.
`default_nettype none

module asa_back #(
  parameter int MAX_BLADES = asa_pkg::MAX_BLADES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  asa_cfg_if.sink                    cfg,
  input  wire asa_pkg::blade_entry_t pop_data,
  input  wire logic                  pop_valid,
  output logic                       pop_ready,
  asa_out_if.source                  slot_out
);

  localparam int IW = $clog2(MAX_BLADES);
  localparam int CW = $clog2(MAX_BLADES + 1);
  localparam logic [2:0] LAST_SLOT = 3'(asa_pkg::SLOT_COUNT - 1);

  asa_pkg::back_state_t state, state_next;

  // Blade store, undefined until written.
  logic signed [15:0] st_x   [MAX_BLADES];
  logic signed [15:0] st_y   [MAX_BLADES];
  logic [3:0]         st_lab [MAX_BLADES];
  logic [15:0]        st_ang [MAX_BLADES];
  logic [IW-1:0]      ord    [MAX_BLADES];

  logic [15:0]        slot_spacing;
  logic [15:0]        slot_tolerance;
  logic [10:0]        wrap_tolerance;

  logic [CW-1:0]      cnt;
  logic               ovf;
  logic [15:0]        prev_ta;
  logic               prev_solved;
  logic [15:0]        ta;
  logic [3:0]         tlab;
  logic [IW-1:0]      tgt;
  logic [16:0]        best;
  logic [IW-1:0]      i;
  logic [IW-1:0]      j;
  logic [IW-1:0]      pos;
  logic signed [16:0] key_rel;
  logic [CW-1:0]      key_rk;
  logic [2:0]         s;
  logic [CW-1:0]      jp;
  logic [18:0]        sang;

  logic [IW-1:0]      rd_idx;
  logic [15:0]        rd_ang;
  logic signed [17:0] raw_rel;
  logic signed [16:0] rd_rel;
  logic [CW-1:0]      rd_rk;
  logic [15:0]        dd;
  logic [16:0]        wrap_dist;
  logic               search_en;
  logic               srch_last;
  logic               before_key;
  logic               have;
  logic signed [19:0] sdiff;
  logic [19:0]        sabs;
  logic               lit_now;
  logic               out_free;
  logic [1:0]         status_now;
  logic [3:0]         cnt_out;
  logic               pop_take;

  // Configuration writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_spacing   <= asa_pkg::SLOT_SPACING_RST;
      slot_tolerance <= asa_pkg::SLOT_TOLERANCE_RST;
      wrap_tolerance <= asa_pkg::WRAP_TOLERANCE_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        asa_pkg::CFG_SLOT_SPACING:   slot_spacing   <= cfg.data;
        asa_pkg::CFG_SLOT_TOLERANCE: slot_tolerance <= cfg.data;
        asa_pkg::CFG_WRAP_TOLERANCE: wrap_tolerance <= cfg.data[10:0];
        default: ;
      endcase
    end
  end

  // Single read port of the store; the address follows the phase.
  always_comb begin
    unique case (state)
      asa_pkg::B_SORT: rd_idx = j;
      asa_pkg::B_EMIT: rd_idx = ord[jp[IW-1:0]];
      default:         rd_idx = i;
    endcase
  end

  assign rd_ang = st_ang[rd_idx];

  // Angle relative to the target, wrapped unless just below zero.
  assign raw_rel = $signed({2'b00, rd_ang}) - $signed({2'b00, ta});
  assign rd_rel  = (raw_rel < -$signed({7'd0, wrap_tolerance}))
                   ? 17'(raw_rel + 18'sd65536) : 17'(raw_rel);
  assign rd_rk   = (rd_idx == tgt) ? '0 : CW'(rd_idx) + CW'(1);

  // Wrapped distance to the previous target angle.
  assign dd        = rd_ang - prev_ta;
  assign wrap_dist = (dd > 16'd32768) ? (17'h10000 - {1'b0, dd}) : {1'b0, dd};

  assign search_en  = (cnt > CW'(1)) && prev_solved;
  assign srch_last  = !search_en || (CW'(i) == cnt - CW'(1));
  assign before_key = (rd_rel < key_rel) || ((rd_rel == key_rel) && (rd_rk < key_rk));

  // Slot match test for the next blade in sorted order.
  assign have    = (jp < cnt);
  assign sdiff   = 20'(rd_rel) - $signed({1'b0, sang});
  assign sabs    = sdiff[19] ? 20'(-sdiff) : 20'(sdiff);
  assign lit_now = have && (sabs < {4'd0, slot_tolerance});

  assign out_free   = !slot_out.valid || slot_out.ready;
  assign status_now = (cnt == '0) ? asa_pkg::ST_EMPTY
                    : (ovf ? asa_pkg::ST_DROPPED : asa_pkg::ST_SOLVED);
  assign cnt_out    = (cnt > CW'(15)) ? 4'd15 : 4'(cnt);

  assign pop_ready = (state == asa_pkg::B_IDLE);
  assign pop_take  = pop_ready && pop_valid;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      asa_pkg::B_IDLE: begin
        if (pop_valid && pop_data.frame_end) state_next = asa_pkg::B_SRCH;
      end
      asa_pkg::B_SRCH: begin
        if (cnt == '0) begin
          state_next = asa_pkg::B_EMIT;
        end else if (srch_last) begin
          state_next = asa_pkg::B_KEY;
        end
      end
      asa_pkg::B_KEY: state_next = asa_pkg::B_SORT;
      asa_pkg::B_SORT: begin
        if (CW'(j) == cnt - CW'(1)) begin
          state_next = (CW'(i) == cnt - CW'(1)) ? asa_pkg::B_EMIT : asa_pkg::B_KEY;
        end
      end
      asa_pkg::B_EMIT: begin
        if (out_free && s == LAST_SLOT) state_next = asa_pkg::B_IDLE;
      end
      default: state_next = asa_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= asa_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Blade store writes.
  always_ff @(posedge clk) begin
    if (pop_take && pop_data.present && cnt < CW'(MAX_BLADES)) begin
      st_x[cnt[IW-1:0]]   <= pop_data.x;
      st_y[cnt[IW-1:0]]   <= pop_data.y;
      st_lab[cnt[IW-1:0]] <= pop_data.label;
      st_ang[cnt[IW-1:0]] <= pop_data.angle;
    end
  end

  // Sorted order table.
  always_ff @(posedge clk) begin
    if (state == asa_pkg::B_SORT && CW'(j) == cnt - CW'(1)) begin
      ord[before_key ? pos + IW'(1) : pos] <= i;
    end
  end

  // Frame control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= '0;
      ovf         <= 1'b0;
      prev_ta     <= '0;
      prev_solved <= 1'b0;
    end else begin
      if (pop_take && pop_data.present) begin
        if (cnt < CW'(MAX_BLADES)) begin
          cnt <= cnt + CW'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
      if (state == asa_pkg::B_SRCH && cnt == '0) begin
        prev_solved <= 1'b0;
      end
      if (state == asa_pkg::B_SORT && state_next == asa_pkg::B_EMIT) begin
        prev_solved <= 1'b1;
        prev_ta     <= ta;
      end
      if (state == asa_pkg::B_EMIT && out_free && s == LAST_SLOT) begin
        cnt <= '0;
        ovf <= 1'b0;
      end
    end
  end

  // Target search, sort and slot walk datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      asa_pkg::B_IDLE: begin
        i <= '0;
      end
      asa_pkg::B_SRCH: begin
        if (cnt == '0) begin
          ta   <= '0;
          tlab <= '0;
          tgt  <= '0;
          s    <= '0;
          jp   <= '0;
          sang <= '0;
        end else begin
          if (i == '0 || wrap_dist < best) begin
            best <= wrap_dist;
            tgt  <= i;
            ta   <= rd_ang;
            tlab <= st_lab[rd_idx];
          end
          i <= srch_last ? '0 : i + IW'(1);
        end
      end
      asa_pkg::B_KEY: begin
        key_rel <= rd_rel;
        key_rk  <= rd_rk;
        pos     <= '0;
        j       <= '0;
      end
      asa_pkg::B_SORT: begin
        if (before_key) pos <= pos + IW'(1);
        j <= j + IW'(1);
        if (CW'(j) == cnt - CW'(1)) begin
          i    <= i + IW'(1);
          s    <= '0;
          jp   <= '0;
          sang <= '0;
        end
      end
      asa_pkg::B_EMIT: begin
        if (out_free) begin
          s    <= s + 3'd1;
          sang <= sang + {3'd0, slot_spacing};
          if (lit_now) jp <= jp + CW'(1);
        end
      end
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_out.valid <= 1'b0;
    end else if (state == asa_pkg::B_EMIT && out_free) begin
      slot_out.valid <= 1'b1;
    end else if (slot_out.ready) begin
      slot_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == asa_pkg::B_EMIT && out_free) begin
      slot_out.slot_index     <= s;
      slot_out.lit            <= lit_now;
      slot_out.is_target      <= lit_now && (rd_idx == tgt);
      slot_out.point_x        <= lit_now ? st_x[rd_idx] : 16'sd0;
      slot_out.point_y        <= lit_now ? st_y[rd_idx] : 16'sd0;
      slot_out.matched_label  <= lit_now ? st_lab[rd_idx] : 4'd0;
      slot_out.relative_angle <= lit_now ? rd_rel : 17'sd0;
      slot_out.target_label   <= tlab;
      slot_out.tgt_angle      <= ta;
      slot_out.blade_count    <= cnt_out;
      slot_out.status         <= status_now;
      slot_out.last           <= (s == LAST_SLOT);
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/angular_slot_assigner.sv
// Top level of the angular slot assigner: front, queue and back.
// Depends on asa_pkg, asa_if, asa_front, asa_queue and asa_back.
//
//   channel    dir  transaction
//   blade_in   in   one blade point or empty marker, frame_end closes the frame
//   slot_out   out  one slot result, five per frame, last on the fifth
//   cfg        in   register write: index 0 spacing, 1 tolerance, 2 wrap tolerance
//
// A blade passes the front's CORDIC one step per cycle; an item without a blade skips
// the CORDIC, and the front takes a new item only after the last one is pushed on.
// A frame end starts a target search, a sort and a slot walk in the back, held by output
// stalls and paced by the single store read port.
// Reset is synchronous and active high; the store needs no clearing pass.
// The queue lets the front keep taking blades while the back waits on slot_out.
`default_nettype none

module angular_slot_assigner #(
  parameter int MAX_BLADES   = asa_pkg::MAX_BLADES_DEF,
  parameter int CORDIC_STEPS = asa_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  asa_in_if.sink    blade_in,
  asa_out_if.source slot_out,
  asa_cfg_if.sink   cfg
);

  asa_pkg::blade_entry_t push_data;
  asa_pkg::blade_entry_t pop_data;
  logic                  push_valid;
  logic                  push_ready;
  logic                  pop_valid;
  logic                  pop_ready;

  // Angle unit.
  asa_front #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .blade_in  (blade_in),
    .push_data (push_data),
    .push_valid(push_valid),
    .push_ready(push_ready)
  );

  // Decoupling queue.
  asa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_data (push_data),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .pop_data  (pop_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready)
  );

  // Frame solver.
  asa_back #(
    .MAX_BLADES(MAX_BLADES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .pop_data (pop_data),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .slot_out (slot_out)
  );

endmodule

`default_nettype wire

>>> hw/rtl/asa_checker.sv
// Port-level checks of the angular slot assigner's result channel.
// Depends on asa_pkg; bound to the top level at the end of this file.
`default_nettype none

module asa_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [2:0]        slot_index,
  input wire logic              lit,
  input wire logic              is_target,
  input wire logic signed [15:0] point_x,
  input wire logic [3:0]        matched_label,
  input wire logic [3:0]        blade_count,
  input wire logic [1:0]        status
);

  // A stalled result holds its slot number.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(slot_index))
    else $error("result changed while stalled");

  // Slot numbers advance by one within a frame.
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && slot_index != 3'(asa_pkg::SLOT_COUNT - 1) ##1 out_valid
    |-> slot_index == $past(slot_index) + 3'd1)
    else $error("slot order broken");

  // Unlit slots carry no blade.
  a_unlit: assert property (@(posedge clk) disable iff (rst)
    out_valid && !lit |-> !is_target && point_x == 16'sd0 && matched_label == 4'd0)
    else $error("unlit slot carries blade data");

  // An empty frame lights nothing.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == asa_pkg::ST_EMPTY |-> !lit && blade_count == 4'd0)
    else $error("empty frame shows a blade");

  // A frame with blades reports a solved or dropped status.
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && blade_count != 4'd0
    |-> status == asa_pkg::ST_SOLVED || status == asa_pkg::ST_DROPPED)
    else $error("status does not match blade count");

endmodule

bind angular_slot_assigner asa_checker u_asa_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (slot_out.valid),
  .out_ready    (slot_out.ready),
  .slot_index   (slot_out.slot_index),
  .lit          (slot_out.lit),
  .is_target    (slot_out.is_target),
  .point_x      (slot_out.point_x),
  .matched_label(slot_out.matched_label),
  .blade_count  (slot_out.blade_count),
  .status       (slot_out.status)
);

`default_nettype wire
